// ===== sv/rbs_pkg.sv =====
// rbs_pkg: shared types, constants and helper function of the ray/box slab test
// fixed-point format, payload structs, config indices; no dependencies
package rbs_pkg;

  localparam int COORD_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int SIZE_BITS    = COORD_BITS - 1;
  localparam int QUOT_BITS    = 2 * FRAC_BITS + 1;
  localparam int PROD_BITS    = 2 * COORD_BITS + 1;
  localparam int NUM_AXES     = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0] size_t;

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam size_t BOX_SIZE_RESET = SIZE_BITS'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_SIZE_Z = 3'd5;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t bound_entry_in;
    coord_t bound_exit_in;
  } ray_in_t;

  typedef struct packed {
    logic   hit;
    coord_t entry_t;
    coord_t exit_t;
  } ray_out_t;

  typedef struct packed {
    coord_t [NUM_AXES-1:0] box_min;
    size_t  [NUM_AXES-1:0] box_size;
  } box_cfg_t;

  // classified axis: direction sign, zero flag and magnitude, in-slab flag, box_min - origin
  typedef struct packed {
    logic                   neg;
    logic                   zero;
    logic                   in_slab;
    logic [COORD_BITS-1:0]  mag;
    logic signed [COORD_BITS:0] diff;
  } axis_t;

  typedef struct packed {
    axis_t [NUM_AXES-1:0] ax;
    coord_t               bound_entry;
    coord_t               bound_exit;
  } item_t;

  typedef struct packed {
    item_t                                it;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]  rem;
    logic [NUM_AXES-1:0][QUOT_BITS-1:0]   quo;
  } div_stage_t;

  // sign and magnitude back to a saturated coordinate
  function automatic coord_t sat_mag(input logic neg, input logic [PROD_BITS-1:0] mag);
    logic [PROD_BITS-1:0] lim;
    logic [PROD_BITS-1:0] nm;
    lim = PROD_BITS'(1) << (COORD_BITS - 1);
    nm  = ~mag + PROD_BITS'(1);
    if (neg) begin
      return (mag >= lim) ? CMIN : coord_t'(nm[COORD_BITS-1:0]);
    end
    return (mag >= lim) ? CMAX : coord_t'(mag[COORD_BITS-1:0]);
  endfunction

endpackage

// ===== sv/rbs_front.sv =====
// rbs_front: classifies each ray per axis before it enters the queue
// depends on rbs_pkg
module rbs_front (
  input  rbs_pkg::ray_in_t  ray,
  input  rbs_pkg::box_cfg_t cfg,
  output rbs_pkg::item_t    item
);
  import rbs_pkg::*;

  coord_t [NUM_AXES-1:0] org;
  coord_t [NUM_AXES-1:0] dir;

  assign org = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign dir = {ray.dir_z, ray.dir_y, ray.dir_x};

  always_comb begin
    item.bound_entry = ray.bound_entry_in;
    item.bound_exit  = ray.bound_exit_in;
    for (int a = 0; a < NUM_AXES; a++) begin
      item.ax[a].neg  = dir[a][COORD_BITS-1];
      item.ax[a].zero = (dir[a] == '0);
      item.ax[a].mag  = dir[a][COORD_BITS-1] ? (~dir[a] + COORD_BITS'(1)) : dir[a];
      item.ax[a].diff = $signed({cfg.box_min[a][COORD_BITS-1], cfg.box_min[a]})
                      - $signed({org[a][COORD_BITS-1], org[a]});
      // origin within the slab, used when the direction is zero
      item.ax[a].in_slab = (item.ax[a].diff <= 0)
                        && ((-item.ax[a].diff) <= $signed({2'b00, cfg.box_size[a]}));
    end
  end

endmodule

// ===== sv/rbs_queue.sv =====
// rbs_queue: short register queue between classification and the slab pipeline
// depends on rbs_pkg
module rbs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            full,
  input  rbs_pkg::item_t  push_data,
  output logic            head_valid,
  input  logic            pop,
  output rbs_pkg::item_t  head_data
);
  import rbs_pkg::*;

  item_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                 push;

  assign full       = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign push       = push_valid && !full;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QPTR_BITS+1)'(1);
    else if (!push && pop) cnt_nxt = cnt_r - (QPTR_BITS+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== sv/rbs_back.sv =====
// rbs_back: reciprocal divider, slab products, slab intersection, output register
// depends on rbs_pkg
module rbs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rbs_pkg::box_cfg_t cfg,
  input  logic              head_valid,
  input  rbs_pkg::item_t    head_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output rbs_pkg::ray_out_t out_data
);
  import rbs_pkg::*;

  function automatic div_stage_t div_step(input div_stage_t s, input logic nbit);
    div_stage_t r;
    logic [COORD_BITS:0] sh;
    logic qb;
    r = s;
    for (int a = 0; a < NUM_AXES; a++) begin
      sh = {s.rem[a], nbit};
      qb = (sh >= {1'b0, s.it.ax[a].mag});
      if (qb) sh = sh - {1'b0, s.it.ax[a].mag};
      r.rem[a] = sh[COORD_BITS-1:0];
      r.quo[a] = {s.quo[a][QUOT_BITS-2:0], qb};
    end
    return r;
  endfunction

  logic en;
  div_stage_t             div_r [QUOT_BITS];
  logic [QUOT_BITS-1:0]   dv_r;
  div_stage_t             div_init;

  item_t                  itv_r, itm_r, itp_r;
  logic                   vv_r, vm_r, vp_r, vc_r;
  coord_t [NUM_AXES-1:0]  inv_r;
  logic [NUM_AXES-1:0]    inv_neg_r, pn_neg_r;
  logic [PROD_BITS-1:0]   pn_mag_r [NUM_AXES];
  logic [PROD_BITS-1:0]   pf_mag_r [NUM_AXES];
  coord_t [NUM_AXES-1:0]  lo_r, hi_r;
  logic [NUM_AXES-1:0]    ok_r;
  coord_t                 be_p_r, bx_p_r, be_c_r, bx_c_r;
  logic                   hit_c_r;
  coord_t                 tmin_c_r, tmax_c_r, lo_z_r, hi_z_r;
  logic                   ok_z_r;
  logic                   out_valid_r;
  ray_out_t               out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign pop       = en && head_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    div_init.it  = head_data;
    div_init.rem = '0;
    div_init.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      vv_r        <= 1'b0;
      vm_r        <= 1'b0;
      vp_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_r        <= {dv_r[QUOT_BITS-2:0], head_valid};
      vv_r        <= dv_r[QUOT_BITS-1];
      vm_r        <= vv_r;
      vp_r        <= vm_r;
      vc_r        <= vp_r;
      out_valid_r <= vc_r;
    end
  end

  // one quotient bit per stage; the dividend 2^(2*FRAC_BITS) has only its top bit set
  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= div_step(div_init, 1'b1);
      for (int k = 1; k < QUOT_BITS; k++) div_r[k] <= div_step(div_r[k-1], 1'b0);
    end
  end

  // saturated signed reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      itv_r <= div_r[QUOT_BITS-1].it;
      for (int a = 0; a < NUM_AXES; a++) begin
        inv_r[a] <= sat_mag(div_r[QUOT_BITS-1].it.ax[a].neg,
                            PROD_BITS'(div_r[QUOT_BITS-1].quo[a]));
      end
    end
  end

  // slab products as sign and magnitude
  always_ff @(posedge clk) begin
    logic [COORD_BITS:0]   ma;
    logic [COORD_BITS-1:0] mb;
    if (en) begin
      itm_r <= itv_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        ma = itv_r.ax[a].diff[COORD_BITS] ? (~itv_r.ax[a].diff + (COORD_BITS+1)'(1))
                                           : itv_r.ax[a].diff;
        mb = inv_r[a][COORD_BITS-1] ? (~inv_r[a] + COORD_BITS'(1)) : inv_r[a];
        inv_neg_r[a] <= inv_r[a][COORD_BITS-1];
        pn_neg_r[a]  <= itv_r.ax[a].diff[COORD_BITS] ^ inv_r[a][COORD_BITS-1];
        pn_mag_r[a]  <= PROD_BITS'(ma) * PROD_BITS'(mb);
        pf_mag_r[a]  <= PROD_BITS'(cfg.box_size[a]) * PROD_BITS'(mb);
      end
    end
  end

  // near/far distances, swapped for a negative reciprocal; a zero direction gives the full range and the in-slab flag
  always_ff @(posedge clk) begin
    coord_t near_v, fp_v, far_v;
    logic signed [COORD_BITS:0] sum;
    if (en) begin
      be_p_r <= itm_r.bound_entry;
      bx_p_r <= itm_r.bound_exit;
      for (int a = 0; a < NUM_AXES; a++) begin
        near_v = sat_mag(pn_neg_r[a], pn_mag_r[a] >> FRAC_BITS);
        fp_v   = sat_mag(inv_neg_r[a], pf_mag_r[a] >> FRAC_BITS);
        sum    = $signed({near_v[COORD_BITS-1], near_v}) + $signed({fp_v[COORD_BITS-1], fp_v});
        if (sum[COORD_BITS] != sum[COORD_BITS-1]) far_v = sum[COORD_BITS] ? CMIN : CMAX;
        else far_v = coord_t'(sum[COORD_BITS-1:0]);
        if (itm_r.ax[a].zero) begin
          lo_r[a] <= CMIN;
          hi_r[a] <= CMAX;
          ok_r[a] <= itm_r.ax[a].in_slab;
        end else begin
          lo_r[a] <= inv_neg_r[a] ? far_v : near_v;
          hi_r[a] <= inv_neg_r[a] ? near_v : far_v;
          ok_r[a] <= 1'b1;
        end
      end
    end
  end

  // x against y
  always_ff @(posedge clk) begin
    if (en) begin
      hit_c_r  <= ok_r[0] && ok_r[1] && !($signed(lo_r[0]) > $signed(hi_r[1]))
                  && !($signed(lo_r[1]) > $signed(hi_r[0]));
      tmin_c_r <= ($signed(lo_r[1]) > $signed(lo_r[0])) ? lo_r[1] : lo_r[0];
      tmax_c_r <= ($signed(hi_r[1]) < $signed(hi_r[0])) ? hi_r[1] : hi_r[0];
      lo_z_r   <= lo_r[2];
      hi_z_r   <= hi_r[2];
      ok_z_r   <= ok_r[2];
      be_c_r   <= be_p_r;
      bx_c_r   <= bx_p_r;
    end
  end

  // z slab and the incoming bounds
  always_ff @(posedge clk) begin
    logic   hit_v;
    coord_t tmin_v, tmax_v;
    if (en) begin
      hit_v  = hit_c_r && ok_z_r && !($signed(tmin_c_r) > $signed(hi_z_r))
               && !($signed(lo_z_r) > $signed(tmax_c_r));
      tmin_v = ($signed(lo_z_r) > $signed(tmin_c_r)) ? lo_z_r : tmin_c_r;
      tmax_v = ($signed(hi_z_r) < $signed(tmax_c_r)) ? hi_z_r : tmax_c_r;
      out_data_r.hit     <= hit_v;
      out_data_r.entry_t <= (hit_v && ($signed(tmin_v) > $signed(be_c_r))) ? tmin_v : be_c_r;
      out_data_r.exit_t  <= (hit_v && ($signed(tmax_v) < $signed(bx_c_r))) ? tmax_v : bx_c_r;
    end
  end

endmodule

// ===== sv/ray_box_slab_intersect.sv =====
// ray_box_slab_intersect: top level, box registers and the front/queue/back chain
// depends on rbs_pkg, rbs_front, rbs_queue, rbs_back
//
// One ray per beat on the in_ channel (origin, direction, entry/exit bound);
// one result per ray on the out_ channel (hit flag, tightened entry/exit).
// Box corner and size are written through cfg_wr_en/cfg_index/cfg_wdata,
// which the user must do only while no ray is in flight; the block does not
// enforce it, and unknown indices are ignored. A ray is classified on accept
// and parked in a four-entry queue. From there it runs a 33-stage reciprocal
// divider (one quotient bit per stage), then reciprocal, product, slab and
// two intersection stages, ending in the output register. While out_stall
// is low, throughput is one ray per cycle, set by the fully pipelined
// divider. While out_valid and out_stall are both high the whole back
// pipeline holds; the queue keeps taking rays until it is full, then
// in_stall rises. Reset (rst_n low, synchronous) empties queue and pipeline
// and sets the box to corner 0, size 1.0 on every axis.
module ray_box_slab_intersect (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rbs_pkg::ray_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rbs_pkg::ray_out_t                   out_data,
  input  logic                                cfg_wr_en,
  input  logic [rbs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rbs_pkg::COORD_BITS-1:0]      cfg_wdata
);
  import rbs_pkg::*;

  box_cfg_t cfg_r;
  item_t    front_item, head_data;
  logic     head_valid, pop, full;

  assign in_stall = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_min  <= '0;
      cfg_r.box_size <= {NUM_AXES{BOX_SIZE_RESET}};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BOX_MIN_X:  cfg_r.box_min[0]  <= cfg_wdata;
        CFG_BOX_MIN_Y:  cfg_r.box_min[1]  <= cfg_wdata;
        CFG_BOX_MIN_Z:  cfg_r.box_min[2]  <= cfg_wdata;
        CFG_BOX_SIZE_X: cfg_r.box_size[0] <= cfg_wdata[SIZE_BITS-1:0];
        CFG_BOX_SIZE_Y: cfg_r.box_size[1] <= cfg_wdata[SIZE_BITS-1:0];
        CFG_BOX_SIZE_Z: cfg_r.box_size[2] <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  rbs_front u_front (
    .ray  (in_data),
    .cfg  (cfg_r),
    .item (front_item)
  );

  rbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .full       (full),
    .push_data  (front_item),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  rbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== test/tb_ray_box_slab_intersect.sv =====
// tb_ray_box_slab_intersect: self-checking bench for the ray/box slab test block
// depends on rbs_pkg and ray_box_slab_intersect; predicts each result in fixed point
module tb_ray_box_slab_intersect;
  import rbs_pkg::*;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  ray_in_t in_data;
  ray_out_t out_data;
  logic cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0] cfg_wdata;

  ray_box_slab_intersect DUT (.*);

  ray_in_t pending_rays[$];
  ray_out_t expected_hits[$];
  longint box_lo[3];
  longint box_ext[3];
  int errors = 0;
  int idle_pct = 38;
  int watchdog = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp_coord(longint v);
    if (v > LMAX) return LMAX;
    if (v < LMIN) return LMIN;
    return v;
  endfunction

  // signed Q16.16 product, magnitude truncated, saturated
  function automatic longint fixed_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] ma, mb;
    logic neg;
    neg = (a < 0) != (b < 0);
    ma = 128'(a < 0 ? -a : a);
    mb = 128'(b < 0 ? -b : b);
    p = (ma * mb) >> FRAC_BITS;
    if (neg) return p >= 128'h80000000 ? LMIN : -longint'(p);
    return p > 128'h7fffffff ? LMAX : longint'(p);
  endfunction

  function automatic bit slab_range(int ax, longint o, longint d,
                                    output longint lo, output longint hi);
    longint inv, nv, fv;
    longint unsigned q;
    if (d == 0) begin
      lo = LMIN;
      hi = LMAX;
      return o >= box_lo[ax] && (o - box_lo[ax]) <= box_ext[ax];
    end
    q = (64'd1 << (2 * FRAC_BITS)) / longint'(d < 0 ? -d : d);
    if (d < 0) inv = q >= 64'h80000000 ? LMIN : -longint'(q);
    else inv = q > 64'h7fffffff ? LMAX : longint'(q);
    nv = fixed_mul(box_lo[ax] - o, inv);
    fv = clamp_coord(nv + fixed_mul(box_ext[ax], inv));
    if (inv < 0) begin
      lo = fv; hi = nv;
    end else begin
      lo = nv; hi = fv;
    end
    return 1;
  endfunction

  function automatic ray_out_t trace_ray(ray_in_t r);
    ray_out_t res;
    longint o[3], d[3];
    longint tmin, tmax, lo, hi, ent, ext;
    bit hit;
    o[0] = longint'(r.origin_x); o[1] = longint'(r.origin_y); o[2] = longint'(r.origin_z);
    d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
    ent = longint'(r.bound_entry_in);
    ext = longint'(r.bound_exit_in);
    hit = slab_range(0, o[0], d[0], tmin, tmax);
    for (int a = 1; a < 3; a++) begin
      if (hit) begin
        if (!slab_range(a, o[a], d[a], lo, hi) || tmin > hi || lo > tmax) hit = 0;
        else begin
          if (lo > tmin) tmin = lo;
          if (hi < tmax) tmax = hi;
        end
      end
    end
    if (hit) begin
      if (tmin > ent) ent = tmin;
      if (tmax < ext) ext = tmax;
    end
    res.hit = hit;
    res.entry_t = coord_t'(ent);
    res.exit_t = coord_t'(ext);
    return res;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 1) ? CMAX : CMIN);
      1: return 0;
      2: return coord_t'($signed($urandom_range(0, 8)) - 4);
      3: return coord_t'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // rays aimed roughly through the box so most reach the later slabs
  function automatic ray_in_t aimed_ray();
    ray_in_t r;
    r.origin_x = coord_t'(box_lo[0] + $signed($urandom_range(0, 32'h60000)) - 32'sh30000);
    r.origin_y = coord_t'(box_lo[1] + $signed($urandom_range(0, 32'h60000)) - 32'sh30000);
    r.origin_z = coord_t'(box_lo[2] + $signed($urandom_range(0, 32'h60000)) - 32'sh30000);
    r.dir_x = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    r.dir_y = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    r.dir_z = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    if ($urandom_range(0, 9) == 0) r.dir_y = 0;
    r.bound_entry_in = $urandom_range(0, 1) ? CMIN : rand_coord();
    r.bound_exit_in = $urandom_range(0, 1) ? CMAX : rand_coord();
    return r;
  endfunction

  function automatic ray_in_t noise_ray();
    ray_in_t r;
    r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
    r.dir_x = rand_coord(); r.dir_y = rand_coord(); r.dir_z = rand_coord();
    r.bound_entry_in = rand_coord(); r.bound_exit_in = rand_coord();
    return r;
  endfunction

  function automatic ray_in_t make_ray(coord_t ox, oy, oz, dx, dy, dz, be, bx);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.bound_entry_in = be; r.bound_exit_in = bx;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) void'(pending_rays.pop_front());
      if (!(in_valid && in_stall)) begin
        if (pending_rays.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid <= 1;
          in_data <= pending_rays[0];
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ray_out_t want;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (in_valid && !in_stall) expected_hits.push_back(trace_ray(in_data));
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          errors++;
        end else begin
          want = expected_hits.pop_front();
          if (want.hit !== out_data.hit)
            $display("%0t: hit expected %b actual %b", $time, want.hit, out_data.hit);
          if (want.entry_t !== out_data.entry_t)
            $display("%0t: entry_t expected %h actual %h", $time, want.entry_t,
                     out_data.entry_t);
          if (want.exit_t !== out_data.exit_t)
            $display("%0t: exit_t expected %h actual %h", $time, want.exit_t,
                     out_data.exit_t);
          if (want !== out_data) errors++;
        end
      end
      out_stall <= $urandom_range(0, 99) < idle_pct;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] v);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (idx <= CFG_BOX_MIN_Z) box_lo[idx] = longint'(coord_t'(v));
    else if (idx <= CFG_BOX_SIZE_Z)
      box_ext[idx - CFG_BOX_SIZE_X] = longint'(v[SIZE_BITS-1:0]);
  endtask

  task automatic drain();
    while (pending_rays.size() != 0 || expected_hits.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_box(logic [COORD_BITS-1:0] mx, my, mz, sx, sy, sz);
    drain();
    write_reg(CFG_BOX_MIN_X, mx);
    write_reg(CFG_BOX_MIN_Y, my);
    write_reg(CFG_BOX_MIN_Z, mz);
    write_reg(CFG_BOX_SIZE_X, sx);
    write_reg(CFG_BOX_SIZE_Y, sy);
    write_reg(CFG_BOX_SIZE_Z, sz);
    write_reg(3'd7, $urandom); // unknown index, no effect
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      pending_rays.push_back($urandom_range(0, 99) < 75 ? aimed_ray() : noise_ray());
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_wr_en = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_ext[a] = 65536;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed rays against the reset box
    pending_rays.push_back(make_ray(-32'sh10000, 32'sh8000, 32'sh8000, 32'sh10000, 0, 0,
                                    CMIN, CMAX));
    pending_rays.push_back(make_ray(32'sh8000, -32'sh10000, 32'sh8000, 0, 0, 32'sh10000,
                                    0, CMAX));
    pending_rays.push_back(make_ray(32'sh30000, 32'sh8000, 32'sh8000, -32'sh10000, 0, 0,
                                    CMIN, CMAX));
    pending_rays.push_back(make_ray(0, 0, 0, 1, -1, 1, CMIN, CMAX));
    pending_rays.push_back(make_ray(0, 0, 0, CMAX, CMIN, CMIN, CMAX, CMIN));
    pending_rays.push_back(make_ray(CMAX, CMIN, 0, 32'sh10000, 32'sh10000, 0, 0, 0));
    pending_rays.push_back(make_ray(32'sh8000, 32'sh8000, 32'sh8000, 0, 0, 0, 5, 7));
    pending_rays.push_back(make_ray(32'sh10000, 0, 32'sh10000, 0, 0, 0, CMIN, CMAX));
    pending_rays.push_back(make_ray(32'sh10001, 0, 0, 0, 32'sh10000, 0, 0, CMAX));
    pending_rays.push_back(make_ray(-1, 0, 0, 0, 0, 32'sh10000, 0, CMAX));
    pending_rays.push_back(make_ray(-32'sh50000, -32'sh50000, -32'sh50000,
                                    32'sh10000, 32'sh10000, 32'sh10000, 32'sh1000,
                                    32'sh2000));
    pending_rays.push_back(make_ray(0, 32'sh40000, 0, 32'sh10000, -32'sh10000, 0,
                                    CMIN, CMAX));
    pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_rays.push_back(make_ray(0, 0, 0, 32'sh7fffffff, 32'sh20000, -32'sh20000,
                                    CMIN, CMAX));
    random_phase(200);

    load_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff);
    pending_rays.push_back(make_ray(CMIN, CMAX, 0, 0, 0, 0, 0, 0));
    pending_rays.push_back(make_ray(CMAX, CMAX, CMAX, 1, 1, 1, CMIN, CMAX));
    random_phase(200);

    load_box(32'h7fffffff, 32'h7fff0000, 32'hffff0000, 0, 0, 0);
    pending_rays.push_back(make_ray(CMAX, 32'sh7fff0000, -32'sh10000, 0, 0, 0, 1, 2));
    random_phase(150);

    // long stretch with no idling
    load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    idle_pct = 0;
    random_phase(250);

    load_box(-32'sh18000, 32'sh4000, 0, 32'sh30000, 32'sh800, 32'sh10000);
    idle_pct = 38;
    random_phase(200);

    load_box(0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
    random_phase(200);

    drain();
    if (errors == 0 && expected_hits.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
